@@ hw/rtl/drflcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Dirty-row flush LCD package
// Shared types, command codes, microcode field codes and link constants for
// the dirty-row flush engine of the serial graphic LCD.
// ----------------------------------------------------------------------------
package drflcd_pkg;

   // Default frame geometry in pixels.
   localparam int DEF_ROWS = 64;
   localparam int DEF_COLS = 128;

   // Request command codes.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_RECT  = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   // Serial link framing constants.
   localparam logic [7:0] SYNC_CMD      = 8'hF8;
   localparam logic [7:0] SYNC_DATA     = 8'hFA;
   localparam logic [7:0] GRAPHICS_ADDR = 8'h80;
   localparam logic [7:0] HIGH_NIBBLE   = 8'hF0;

   // Output selection field of a control word.
   localparam logic [2:0] EMIT_NONE      = 3'd0;
   localparam logic [2:0] EMIT_SYNC_CMD  = 3'd1;
   localparam logic [2:0] EMIT_SYNC_DATA = 3'd2;
   localparam logic [2:0] EMIT_HIGH      = 3'd3;
   localparam logic [2:0] EMIT_LOW       = 3'd4;
   localparam logic [2:0] EMIT_EMPTY     = 3'd5;

   // Byte register load field of a control word.
   localparam logic [1:0] LOAD_HOLD     = 2'd0;
   localparam logic [1:0] LOAD_ROW_WORD = 2'd1;
   localparam logic [1:0] LOAD_COL_WORD = 2'd2;
   localparam logic [1:0] LOAD_MEM      = 2'd3;

   // One input request.
   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] row;
      logic [3:0] byte_col;
      logic [7:0] pixel_byte;
      logic [6:0] rect_first_row;
      logic [6:0] rect_last_row;
      logic [7:0] rect_first_col;
      logic [7:0] rect_last_col;
   } req_type;

   // One result.
   typedef struct packed {
      logic [7:0] spi_byte;
      logic       byte_valid;
      logic       end_of_run;
      logic       more_pending;
   } rsp_type;

   // Datapath controls decoded from the current microcode step.
   typedef struct packed {
      logic [2:0] emit;
      logic [1:0] load;
      logic       setup;
      logic       addr_inc;
      logic       word_step;
      logic       clear_wr;
      logic       idle;
   } ctrl_type;

   // Datapath conditions that the sequencer branches on.
   typedef struct packed {
      logic clearing;
      logic empty;
      logic more_words;
   } status_type;

endpackage

@@ hw/rtl/dirty_row_flush_serial_lcd.sv @@
// ----------------------------------------------------------------------------
// Dirty-row flush engine for a serial graphic LCD
// Keeps a one-bit-per-pixel frame store and a dirty rectangle, and on each
// flush request sends the next dirty row as framed serial link bytes.
//
//   Channel   Ports                        Handshake
//   request   start, busy, req_data        taken when start is high, busy low
//   result    rsp_valid, rsp_data          one cycle each, cannot be stalled
//
// A frame write or rectangle request leaves busy low. A flush request keeps
// busy high until its last result, and its results come one per cycle
// without gaps; an empty flush gives a single result.
// The step rate is set by the microcode loop of six steps per 16-pixel word.
// After reset the frame store is cleared one entry per cycle, all
// ROWS * COLS / 8 entries (1024 by default), with busy high.
// The receiver cannot stall: every result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module dirty_row_flush_serial_lcd #(
   parameter int ROWS = drflcd_pkg::DEF_ROWS,
   parameter int COLS = drflcd_pkg::DEF_COLS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  drflcd_pkg::req_type req_data,
   output logic                rsp_valid,
   output drflcd_pkg::rsp_type rsp_data
);
   import drflcd_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   logic       req_accept;
   logic       flush_req;

   // Requests are taken only at the idle step.
   assign busy       = !ctrl.idle;
   assign req_accept = start && ctrl.idle;
   assign flush_req  = start && (req_data.cmd == CMD_FLUSH);

   drflcd_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .flush_req (flush_req),
      .status    (status),
      .ctrl      (ctrl)
   );

   drflcd_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req        (req_data),
      .req_accept (req_accept),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_data)
   );

endmodule

@@ hw/rtl/drflcd_useq.sv @@
// ----------------------------------------------------------------------------
// Dirty-row flush LCD microcode sequencer
// Holds the step counter and the control store. Each step issues one control
// word to the datapath and picks its successor from a jump target or a next
// address, depending on one tested condition.
// ----------------------------------------------------------------------------
module drflcd_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   flush_req,
   input  drflcd_pkg::status_type status,
   output drflcd_pkg::ctrl_type   ctrl
);
   import drflcd_pkg::*;

   // Step addresses.
   localparam logic [3:0] STEP_CLEAR  = 4'd0;
   localparam logic [3:0] STEP_IDLE   = 4'd1;
   localparam logic [3:0] STEP_CHECK  = 4'd2;
   localparam logic [3:0] STEP_EMPTY  = 4'd3;
   localparam logic [3:0] STEP_A0_SYN = 4'd4;
   localparam logic [3:0] STEP_A0_HI  = 4'd5;
   localparam logic [3:0] STEP_A0_LO  = 4'd6;
   localparam logic [3:0] STEP_A1_SYN = 4'd7;
   localparam logic [3:0] STEP_A1_HI  = 4'd8;
   localparam logic [3:0] STEP_A1_LO  = 4'd9;
   localparam logic [3:0] STEP_D0_SYN = 4'd10;
   localparam logic [3:0] STEP_D0_HI  = 4'd11;
   localparam logic [3:0] STEP_D0_LO  = 4'd12;
   localparam logic [3:0] STEP_D1_SYN = 4'd13;
   localparam logic [3:0] STEP_D1_HI  = 4'd14;
   localparam logic [3:0] STEP_D1_LO  = 4'd15;

   // Branch conditions.
   localparam logic [2:0] COND_ALWAYS     = 3'd0;
   localparam logic [2:0] COND_CLEARING   = 3'd1;
   localparam logic [2:0] COND_NO_FLUSH   = 3'd2;
   localparam logic [2:0] COND_EMPTY      = 3'd3;
   localparam logic [2:0] COND_MORE_WORDS = 3'd4;

   typedef struct packed {
      ctrl_type   ctrl;
      logic [2:0] cond;
      logic [3:0] jump;
      logic [3:0] next;
   } uword_type;

   logic [3:0] pc_ff;
   logic [3:0] pc_in;
   uword_type  uword;
   logic       taken;

   // Builds one control word.
   function automatic uword_type mk(input logic [2:0] emit, input logic [1:0] load,
                                    input logic setup, input logic addr_inc,
                                    input logic word_step, input logic clear_wr,
                                    input logic idle, input logic [2:0] cond,
                                    input logic [3:0] jump, input logic [3:0] next);
      uword_type w;
      w.ctrl.emit      = emit;
      w.ctrl.load      = load;
      w.ctrl.setup     = setup;
      w.ctrl.addr_inc  = addr_inc;
      w.ctrl.word_step = word_step;
      w.ctrl.clear_wr  = clear_wr;
      w.ctrl.idle      = idle;
      w.cond           = cond;
      w.jump           = jump;
      w.next           = next;
      return w;
   endfunction

   // Control store: one word per step.
   always_comb begin
      unique case (pc_ff)
         STEP_CLEAR:  uword = mk(EMIT_NONE, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                 COND_CLEARING, STEP_CLEAR, STEP_IDLE);
         STEP_IDLE:   uword = mk(EMIT_NONE, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                 COND_NO_FLUSH, STEP_IDLE, STEP_CHECK);
         STEP_CHECK:  uword = mk(EMIT_NONE, LOAD_ROW_WORD, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_EMPTY, STEP_EMPTY, STEP_A0_SYN);
         STEP_EMPTY:  uword = mk(EMIT_EMPTY, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_IDLE, STEP_IDLE);
         STEP_A0_SYN: uword = mk(EMIT_SYNC_CMD, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_A0_HI, STEP_A0_HI);
         STEP_A0_HI:  uword = mk(EMIT_HIGH, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_A0_LO, STEP_A0_LO);
         STEP_A0_LO:  uword = mk(EMIT_LOW, LOAD_COL_WORD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_A1_SYN, STEP_A1_SYN);
         STEP_A1_SYN: uword = mk(EMIT_SYNC_CMD, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_A1_HI, STEP_A1_HI);
         STEP_A1_HI:  uword = mk(EMIT_HIGH, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_A1_LO, STEP_A1_LO);
         STEP_A1_LO:  uword = mk(EMIT_LOW, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_D0_SYN, STEP_D0_SYN);
         STEP_D0_SYN: uword = mk(EMIT_SYNC_DATA, LOAD_MEM, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_D0_HI, STEP_D0_HI);
         STEP_D0_HI:  uword = mk(EMIT_HIGH, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_D0_LO, STEP_D0_LO);
         STEP_D0_LO:  uword = mk(EMIT_LOW, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_D1_SYN, STEP_D1_SYN);
         STEP_D1_SYN: uword = mk(EMIT_SYNC_DATA, LOAD_MEM, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_D1_HI, STEP_D1_HI);
         STEP_D1_HI:  uword = mk(EMIT_HIGH, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_D1_LO, STEP_D1_LO);
         STEP_D1_LO:  uword = mk(EMIT_LOW, LOAD_HOLD, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                                 COND_MORE_WORDS, STEP_D0_SYN, STEP_IDLE);
         default:     uword = mk(EMIT_NONE, LOAD_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, STEP_IDLE, STEP_IDLE);
      endcase
   end

   // Condition test and successor selection.
   always_comb begin
      unique case (uword.cond)
         COND_ALWAYS:     taken = 1'b1;
         COND_CLEARING:   taken = status.clearing;
         COND_NO_FLUSH:   taken = !flush_req;
         COND_EMPTY:      taken = status.empty;
         COND_MORE_WORDS: taken = status.more_words;
         default:         taken = 1'b1;
      endcase
      pc_in = taken ? uword.jump : uword.next;
   end

   // Step counter; reset starts the frame store clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = uword.ctrl;

endmodule

@@ hw/rtl/drflcd_datapath.sv @@
// ----------------------------------------------------------------------------
// Dirty-row flush LCD datapath
// Frame store, dirty rectangle, row pointer, word counters and the serial
// byte framing, all steered by the control word of the sequencer.
// ----------------------------------------------------------------------------
module drflcd_datapath #(
   parameter int ROWS = drflcd_pkg::DEF_ROWS,
   parameter int COLS = drflcd_pkg::DEF_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  drflcd_pkg::ctrl_type   ctrl,
   input  drflcd_pkg::req_type    req,
   input  logic                   req_accept,
   output drflcd_pkg::status_type status,
   output logic                   rsp_valid,
   output drflcd_pkg::rsp_type    rsp
);
   import drflcd_pkg::*;

   localparam int BPR    = COLS / 8;
   localparam int DEPTH  = ROWS * BPR;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [6:0] ROWS_V = 7'(ROWS);
   localparam logic [7:0] COLS_V = 8'(COLS);
   localparam logic [4:0] BPR_V  = 5'(BPR);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);

   logic [7:0] mem [DEPTH];

   logic [6:0]        rb_ff, rb_in, re_ff, re_in, nr_ff, nr_in;
   logic [7:0]        cb_ff, cb_in, ce_ff, ce_in;
   logic [3:0]        w_ff, w_in, wend_ff, wend_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, clr_ff, clr_in;
   logic [7:0]        byte_ff, byte_in, rdata_ff;

   logic [6:0]        row_sel;
   logic [3:0]        w_first;
   logic [3:0]        w_next;
   logic              empty;
   logic              more_words;
   logic              last_word;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   // Status for the sequencer.
   assign empty      = !((ce_ff > cb_ff) && (re_ff > rb_ff));
   assign w_next     = w_ff + 4'd1;
   assign more_words = w_next < wend_ff;
   assign last_word  = ctrl.word_step && !more_words;
   assign status     = '{clearing: (clr_ff != LAST_ADDR), empty: empty,
                         more_words: more_words};

   // Row to flush: restart at the first dirty row when outside the rectangle.
   assign row_sel = ((nr_ff < rb_ff) || (nr_ff >= re_ff)) ? rb_ff : nr_ff;
   assign w_first = cb_ff[7:4];

   // Frame store write port: clearing pass or accepted frame byte.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      if (ctrl.clear_wr) begin
         wr_en = 1'b1;
      end else if (req_accept && (req.cmd == CMD_WRITE) && ({1'b0, req.row} < ROWS_V) &&
                   ({1'b0, req.byte_col} < BPR_V)) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'(32'(req.row) * BPR + 32'(req.byte_col));
         wr_data = req.pixel_byte;
      end
   end

   // Frame store with registered read at the byte address register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[addr_ff];
   end

   // Next values of the rectangle, pointer, counters and byte register.
   always_comb begin
      rb_in   = rb_ff;
      re_in   = re_ff;
      cb_in   = cb_ff;
      ce_in   = ce_ff;
      nr_in   = nr_ff;
      w_in    = w_ff;
      wend_in = wend_ff;
      addr_in = addr_ff;
      clr_in  = clr_ff;
      byte_in = byte_ff;

      if (ctrl.clear_wr && (clr_ff != LAST_ADDR)) begin
         clr_in = clr_ff + ADDR_ONE;
      end

      // New dirty rectangle, bounds saturated to the frame.
      if (req_accept && (req.cmd == CMD_RECT)) begin
         rb_in = (req.rect_first_row > ROWS_V) ? ROWS_V : req.rect_first_row;
         re_in = (req.rect_last_row > ROWS_V) ? ROWS_V : req.rect_last_row;
         cb_in = (req.rect_first_col > COLS_V) ? COLS_V : req.rect_first_col;
         ce_in = (req.rect_last_col > COLS_V) ? COLS_V : req.rect_last_col;
      end

      // Start of a flush: fix the row, claim it and set up the word range.
      if (ctrl.setup && !empty) begin
         nr_in = row_sel;
         if (row_sel == rb_ff) begin
            rb_in = rb_ff + 7'd1;
         end
         w_in    = w_first;
         wend_in = 4'((9'(ce_ff) + 9'd15) >> 4);
         addr_in = ADDR_W'(32'(row_sel) * BPR + 32'({w_first, 1'b0}));
      end

      if (ctrl.addr_inc) begin
         addr_in = addr_ff + ADDR_ONE;
      end

      // End of a word; after the last one, advance or close the rectangle.
      if (ctrl.word_step) begin
         w_in = w_next;
      end
      if (last_word) begin
         if (rb_ff != re_ff) begin
            nr_in = nr_ff + 7'd1;
         end else begin
            rb_in = ROWS_V;
            re_in = '0;
            cb_in = COLS_V;
            ce_in = '0;
            nr_in = '0;
         end
      end

      case (ctrl.load)
         LOAD_ROW_WORD: byte_in = GRAPHICS_ADDR | {3'b000, row_sel[4:0]};
         LOAD_COL_WORD: byte_in = GRAPHICS_ADDR | {4'b0000, w_ff} |
                                  {4'b0000, nr_ff[5], 3'b000};
         LOAD_MEM:      byte_in = rdata_ff;
         default:       byte_in = byte_ff;
      endcase
   end

   // Control registers are reset; the word and byte registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         rb_ff  <= ROWS_V;
         re_ff  <= '0;
         cb_ff  <= COLS_V;
         ce_ff  <= '0;
         nr_ff  <= '0;
         clr_ff <= '0;
      end else begin
         rb_ff  <= rb_in;
         re_ff  <= re_in;
         cb_ff  <= cb_in;
         ce_ff  <= ce_in;
         nr_ff  <= nr_in;
         clr_ff <= clr_in;
      end
      w_ff    <= w_in;
      wend_ff <= wend_in;
      addr_ff <= addr_in;
      byte_ff <= byte_in;
   end

   // Result framing: sync byte, high nibble, low nibble shifted up.
   always_comb begin
      rsp_valid        = 1'b1;
      rsp.spi_byte     = '0;
      rsp.byte_valid   = 1'b1;
      rsp.end_of_run   = last_word;
      rsp.more_pending = last_word && (rb_ff != re_ff);
      unique case (ctrl.emit)
         EMIT_SYNC_CMD:  rsp.spi_byte = SYNC_CMD;
         EMIT_SYNC_DATA: rsp.spi_byte = SYNC_DATA;
         EMIT_HIGH:      rsp.spi_byte = byte_ff & HIGH_NIBBLE;
         EMIT_LOW:       rsp.spi_byte = {byte_ff[3:0], 4'h0};
         EMIT_EMPTY: begin
            rsp.byte_valid   = 1'b0;
            rsp.end_of_run   = 1'b1;
            rsp.more_pending = 1'b0;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/drflcd_checker.sv @@
// ----------------------------------------------------------------------------
// Dirty-row flush LCD port checker
// Watches the top-level ports and flags result sequences that the flush
// engine must never show.
// ----------------------------------------------------------------------------
module drflcd_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input drflcd_pkg::req_type req_data,
   input logic                rsp_valid,
   input drflcd_pkg::rsp_type rsp_data
);
   import drflcd_pkg::*;

   // Results only appear while a flush request is in progress.
   a_rsp_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while the engine is idle");

   // A taken flush request always occupies the engine in the next cycle.
   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == CMD_FLUSH)) |=> busy)
      else $error("flush request taken without the engine going busy");

   // The pending flag and an empty result both belong to the last result.
   a_more_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.more_pending || !rsp_data.byte_valid)) |->
         rsp_data.end_of_run)
      else $error("pending flag or empty result before the end of the run");

   // After the last result the engine returns to idle.
   a_idle_after_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.end_of_run) |=> (!rsp_valid && !busy))
      else $error("engine still active after the end of the run");

endmodule

bind dirty_row_flush_serial_lcd drflcd_checker u_drflcd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

@@ verif/tb_dirty_row_flush_serial_lcd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the dirty-row flush serial LCD engine
// Sends frame writes, rectangle updates and flush requests, predicts every
// framed link byte from a shadow copy of the frame and dirty state, and
// checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_dirty_row_flush_serial_lcd;
   import drflcd_pkg::*;

   localparam int ROWS = DEF_ROWS;
   localparam int COLS = DEF_COLS;
   localparam int FRAME_BYTES = ROWS * COLS / 8;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 64;
   localparam int RANDOM_REQUESTS = 208;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow copy of the frame store and the dirty rectangle.
   logic [7:0]  shadow_frame [0:FRAME_BYTES-1];
   int unsigned shadow_row_begin;
   int unsigned shadow_row_end;
   int unsigned shadow_col_begin;
   int unsigned shadow_col_end;
   int unsigned shadow_next_row;

   // Link bytes still to come, oldest first.
   rsp_type expected_link_bytes [$];

   int error_count;
   int request_count;
   int flush_count;
   int byte_count;
   int idle_cycles;
   bit no_gaps;

   dirty_row_flush_serial_lcd uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Free-running 2 ns clock.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
      end
   endtask

   function automatic int unsigned clamp(input int unsigned value, input int unsigned limit);
      return (value > limit) ? limit : value;
   endfunction

   function automatic req_type make_request(input logic [1:0] cmd, input int row,
                                            input int byte_col, input int pixels,
                                            input int first_row, input int last_row,
                                            input int first_col, input int last_col);
      req_type r;
      r.cmd            = cmd;
      r.row            = 6'(row);
      r.byte_col       = 4'(byte_col);
      r.pixel_byte     = 8'(pixels);
      r.rect_first_row = 7'(first_row);
      r.rect_last_row  = 7'(last_row);
      r.rect_first_col = 8'(first_col);
      r.rect_last_col  = 8'(last_col);
      return r;
   endfunction

   task automatic clear_shadow();
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      shadow_row_begin = ROWS;
      shadow_row_end   = 0;
      shadow_col_begin = COLS;
      shadow_col_end   = 0;
      shadow_next_row  = 0;
   endtask

   // One serial byte goes out as sync, high nibble, then low nibble moved up.
   task automatic push_link_byte(input logic [7:0] sync, input logic [7:0] value);
      rsp_type e;
      e.byte_valid   = 1'b1;
      e.end_of_run   = 1'b0;
      e.more_pending = 1'b0;
      e.spi_byte     = sync;
      expected_link_bytes.push_back(e);
      e.spi_byte     = value & HIGH_NIBBLE;
      expected_link_bytes.push_back(e);
      e.spi_byte     = {value[3:0], 4'h0};
      expected_link_bytes.push_back(e);
   endtask

   // Update the shadow state for one accepted request and queue its link bytes.
   task automatic predict_link_bytes(input req_type r);
      int unsigned row_sel;
      int unsigned word;
      int unsigned word_end;
      int unsigned base;
      int unsigned produced;
      rsp_type     tail;
      case (r.cmd)
         CMD_WRITE: begin
            if (r.row < ROWS && r.byte_col < COLS / 8) begin
               shadow_frame[(r.row * (COLS / 8) + r.byte_col) % FRAME_BYTES] = r.pixel_byte;
            end
         end
         CMD_RECT: begin
            shadow_row_begin = clamp(r.rect_first_row, ROWS);
            shadow_row_end   = clamp(r.rect_last_row, ROWS);
            shadow_col_begin = clamp(r.rect_first_col, COLS);
            shadow_col_end   = clamp(r.rect_last_col, COLS);
         end
         CMD_FLUSH: begin
            if (!(shadow_col_end > shadow_col_begin && shadow_row_end > shadow_row_begin)) begin
               // Nothing dirty: a single empty marker.
               tail.spi_byte     = 8'h00;
               tail.byte_valid   = 1'b0;
               tail.end_of_run   = 1'b1;
               tail.more_pending = 1'b0;
               expected_link_bytes.push_back(tail);
            end else begin
               // Restart at the top of the rectangle when the pointer left it.
               if (shadow_next_row < shadow_row_begin || shadow_next_row >= shadow_row_end) begin
                  shadow_next_row = shadow_row_begin;
               end
               if (shadow_next_row == shadow_row_begin) shadow_row_begin++;
               row_sel  = shadow_next_row;
               word     = shadow_col_begin / 16;
               word_end = (shadow_col_end + 15) / 16;
               base     = row_sel * (COLS / 8) + 2 * word;
               push_link_byte(SYNC_CMD, GRAPHICS_ADDR | 8'(row_sel & 31));
               push_link_byte(SYNC_CMD, GRAPHICS_ADDR | 8'(word) | 8'((row_sel & 32) >> 2));
               produced = 6;
               while (word < word_end && produced <= 48) begin
                  push_link_byte(SYNC_DATA, shadow_frame[base % FRAME_BYTES]);
                  push_link_byte(SYNC_DATA, shadow_frame[(base + 1) % FRAME_BYTES]);
                  base += 2;
                  word++;
                  produced += 6;
               end
               // Mark the last byte of the run and advance or retire the rectangle.
               tail = expected_link_bytes.pop_back();
               tail.end_of_run = 1'b1;
               if (shadow_row_begin != shadow_row_end) begin
                  shadow_next_row++;
                  tail.more_pending = 1'b1;
               end else begin
                  shadow_row_begin = ROWS;
                  shadow_col_begin = COLS;
                  shadow_col_end   = 0;
                  shadow_row_end   = 0;
                  shadow_next_row  = 0;
                  tail.more_pending = 1'b0;
               end
               expected_link_bytes.push_back(tail);
            end
         end
         default: begin
            // The unused command leaves everything as it is.
         end
      endcase
   endtask

   // Present one request after a random pause and hold it until it is taken.
   task automatic send_request(input req_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = r;
      start    = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predict_link_bytes(r);
      request_count++;
      if (r.cmd == CMD_FLUSH) flush_count++;
   endtask

   // Check every strobed result against the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_link_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_data));
         end else begin
            want = expected_link_bytes.pop_front();
            compare_field("spi_byte", rsp_data.spi_byte, want.spi_byte);
            compare_field("byte_valid", 8'(rsp_data.byte_valid), 8'(want.byte_valid));
            compare_field("end_of_run", 8'(rsp_data.end_of_run), 8'(want.end_of_run));
            compare_field("more_pending", 8'(rsp_data.more_pending), 8'(want.more_pending));
            byte_count++;
         end
      end
   end

   // Stop the run when neither side moves anything for too long.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no request or result for %0d cycles", IDLE_LIMIT);
         $display("FAIL dirty_row_flush_serial_lcd");
         $finish;
      end
   end

   // Flushing with nothing dirty, including inverted and zero-width rectangles.
   task automatic test_empty_flush();
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(CMD_RECT, 0, 0, 0, 20, 10, 0, 128));
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(CMD_RECT, 0, 0, 0, 5, 9, 64, 64));
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // Frame writes at the corners and around row bit 5.
   task automatic test_frame_extremes();
      send_request(make_request(CMD_WRITE, 0, 0, 8'hFF, 0, 0, 0, 0));
      send_request(make_request(CMD_WRITE, 63, 15, 8'hA5, 0, 0, 0, 0));
      send_request(make_request(CMD_WRITE, 31, 15, 8'h5A, 0, 0, 0, 0));
      send_request(make_request(CMD_WRITE, 32, 14, 8'h81, 0, 0, 0, 0));
      send_request(make_request(CMD_WRITE, 62, 0, 8'h3C, 0, 0, 0, 0));
      send_request(make_request(CMD_WRITE, 63, 1, 8'h00, 0, 0, 0, 0));
   endtask

   // Bounds beyond the frame saturate; the last row retires the rectangle.
   task automatic test_saturated_rect();
      send_request(make_request(CMD_RECT, 0, 0, 0, 62, 127, 0, 255));
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // A new rectangle that leaves the row pointer outside restarts at its top row.
   task automatic test_row_restart();
      send_request(make_request(CMD_RECT, 0, 0, 0, 31, 33, 127, 128));
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(CMD_RECT, 0, 0, 0, 40, 42, 16, 33));
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // The unused command must change nothing.
   task automatic test_unused_command();
      send_request(make_request(CMD_UNUSED, 63, 15, 255, 127, 127, 255, 255));
      send_request(make_request(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // Mostly well-formed traffic with random content, some raw noise.
   task automatic test_random_traffic();
      logic [63:0] bits;
      req_type     r;
      int          pick;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         bits = {$urandom, $urandom};
         r    = bits[$bits(req_type)-1:0];
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            r.cmd = CMD_WRITE;
         end else if (pick < 47) begin
            // Small row spans so that flushes run the rectangle to its end.
            r.cmd            = CMD_RECT;
            r.rect_first_row = 7'($urandom_range(0, ROWS - 1));
            r.rect_last_row  = r.rect_first_row + 7'($urandom_range(1, 4));
            r.rect_first_col = 8'($urandom_range(0, COLS - 1));
            r.rect_last_col  = r.rect_first_col + 8'($urandom_range(1, 255 - r.rect_first_col));
         end else if (pick < 52) begin
            r.cmd = CMD_RECT;
         end else if (pick < 96) begin
            r.cmd = CMD_FLUSH;
         end else begin
            r.cmd = CMD_UNUSED;
         end
         send_request(r);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      error_count   = 0;
      request_count = 0;
      flush_count   = 0;
      byte_count    = 0;
      idle_cycles   = 0;
      no_gaps       = 1'b0;
      clear_shadow();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_empty_flush();
      test_frame_extremes();
      test_saturated_rect();
      test_row_restart();
      test_unused_command();
      test_random_traffic();

      @(negedge clock);
      start = 1'b0;
      while (expected_link_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, %0d of them flushes; checked %0d link results.",
               request_count, flush_count, byte_count);
      $display("Mismatches found: %0d", error_count);
      if (error_count == 0 && expected_link_bytes.size() == 0) begin
         $display("PASS dirty_row_flush_serial_lcd");
      end else begin
         $display("FAIL dirty_row_flush_serial_lcd");
      end
      $finish;
   end

endmodule
